// ----- rtl/skis_pkg.sv -----
// ----------------------------------------------------------------------------
// skis_pkg
// Shared types and constants for the sorted key index search block.
// ----------------------------------------------------------------------------
package skis_pkg;

  localparam int DEF_TABLE_DEPTH = 128;
  localparam int DEF_KEY_WIDTH   = 32;

  localparam logic [7:0] ENTRIES_RESET = 8'd128;

  // Operation codes of an input item.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_SLOT_ERR  = 2'd2;
  localparam logic [1:0] ST_STALE     = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [6:0]         slot;
    logic signed [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
  } out_item_t;

endpackage

// ----- rtl/skis_ram.sv -----
// ----------------------------------------------------------------------------
// skis_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skis_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/skis_seq.sv -----
// ----------------------------------------------------------------------------
// skis_seq
// Sequencer: key store write, insertion sort of the index, binary search.
// ----------------------------------------------------------------------------
module skis_seq
  import skis_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  in_item_t                         item,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] used,
  input  logic                             cfg_wr,
  output logic                             idle,
  output logic                             done,
  input  logic                             done_ack,
  output out_item_t                        result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = CNT_W + 1;
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [3:0] {
    IDLE, B_START, B_KS, B_PK, B_CMP, B_PLACE, S_MID, S_KEY, S_CMP, DONE
  } state_t;

  state_t                 state;
  logic [KEY_WIDTH-1:0]   ks;
  logic [KEY_WIDTH-1:0]   target;
  logic [CNT_W-1:0]       i;
  logic [CNT_W-1:0]       j;
  logic [IDX_W-1:0]       prev;
  logic [IDX_W-1:0]       cur_slot;
  logic signed [SW-1:0]   lo;
  logic signed [SW-1:0]   hi;
  logic signed [SW-1:0]   mid;
  logic                   index_valid;

  logic                   key_we;
  logic [IDX_W-1:0]       key_waddr;
  logic [KEY_WIDTH-1:0]   key_wdata;
  logic [IDX_W-1:0]       key_raddr;
  logic [KEY_WIDTH-1:0]   key_rdata;
  logic                   idx_we;
  logic [IDX_W-1:0]       idx_waddr;
  logic [IDX_W-1:0]       idx_wdata;
  logic [IDX_W-1:0]       idx_raddr;
  logic [IDX_W-1:0]       idx_rdata;

  logic [63:0]            key_wide;
  logic [KEY_WIDTH-1:0]   key_in;
  logic                   slot_ok;
  logic [CNT_W-1:0]       i_inc;
  logic [CNT_W-1:0]       i_dec;
  logic [CNT_W-1:0]       j_dec;
  logic [CNT_W-1:0]       j_dec2;
  logic                   last_i;
  logic signed [SW-1:0]   mid_c;
  logic signed [SW-1:0]   nlo;
  logic signed [SW-1:0]   nhi;
  logic                   ks_less;
  logic                   kv_less;
  logic [IDX_W+6:0]       pos_ext;

  skis_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(KEY_WIDTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  skis_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(IDX_W)) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (idx_raddr),
    .rdata (idx_rdata)
  );

  always_comb begin
    key_wide = {{32{item.key[31]}}, item.key};
    key_in   = key_wide[KEY_WIDTH-1:0];
    slot_ok  = CW'(item.slot) < CW'(used);
    i_inc    = i + CNT_W'(1);
    i_dec    = i - CNT_W'(1);
    j_dec    = j - CNT_W'(1);
    j_dec2   = j - CNT_W'(2);
    last_i   = (i_inc == used);
    mid_c    = lo + ((hi - lo) >>> 1);
    nlo      = mid + SW'(1);
    nhi      = mid - SW'(1);
    ks_less  = $signed(ks) < $signed(key_rdata);
    kv_less  = $signed(key_rdata) < $signed(target);
    pos_ext  = {7'b0, cur_slot};

    key_we    = (state == IDLE) && start && (item.opcode == OP_WRITE) && slot_ok;
    key_waddr = IDX_W'(item.slot);
    key_wdata = key_in;
    unique case (state)
      B_START: key_raddr = i[IDX_W-1:0];
      B_PK:    key_raddr = idx_rdata;
      S_KEY:   key_raddr = idx_rdata;
      default: key_raddr = i[IDX_W-1:0];
    endcase

    idx_we    = 1'b0;
    idx_waddr = j[IDX_W-1:0];
    idx_wdata = i[IDX_W-1:0];
    if (state == B_PLACE) begin
      idx_we = 1'b1;
    end else if (state == B_CMP) begin
      idx_we = 1'b1;
      if (ks_less) begin
        idx_wdata = prev;
      end
    end
    if (state == S_MID) begin
      idx_raddr = mid_c[IDX_W-1:0];
    end else if (state == B_KS) begin
      idx_raddr = i_dec[IDX_W-1:0];
    end else if (state == B_CMP) begin
      idx_raddr = j_dec2[IDX_W-1:0];
    end else begin
      idx_raddr = j_dec[IDX_W-1:0];
    end
  end

  assign idle = (state == IDLE);
  assign done = (state == DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      index_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        index_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            result <= '{status: ST_OK, position: 7'd0};
            target <= key_in;
            state  <= DONE;
            case (item.opcode)
              OP_WRITE: begin
                if (slot_ok) begin
                  index_valid <= 1'b0;
                end else begin
                  result.status <= ST_SLOT_ERR;
                end
              end
              OP_BUILD: begin
                i <= '0;
                if (used == '0) begin
                  index_valid <= 1'b1;
                end else begin
                  state <= B_START;
                end
              end
              OP_SEARCH: begin
                lo <= '0;
                hi <= SW'(used) - SW'(1);
                if (!index_valid) begin
                  result.status <= ST_STALE;
                end else if (used == '0) begin
                  result.status <= ST_NOT_FOUND;
                end else begin
                  state <= S_MID;
                end
              end
              default: ;
            endcase
          end
        end
        B_START: state <= B_KS;
        B_KS: begin
          // The read of idx[i-1] is issued in this cycle.
          ks <= key_rdata;
          j  <= i;
          state <= (i == '0) ? B_PLACE : B_PK;
        end
        B_PK: begin
          prev  <= idx_rdata;
          state <= B_CMP;
        end
        B_CMP: begin
          if (ks_less) begin
            j <= j_dec;
            state <= (j_dec == '0) ? B_PLACE : B_PK;
          end else begin
            i <= i_inc;
            if (last_i) begin
              index_valid <= 1'b1;
              state       <= DONE;
            end else begin
              state <= B_START;
            end
          end
        end
        B_PLACE: begin
          i <= i_inc;
          if (last_i) begin
            index_valid <= 1'b1;
            state       <= DONE;
          end else begin
            state <= B_START;
          end
        end
        S_MID: begin
          mid   <= mid_c;
          state <= S_KEY;
        end
        S_KEY: begin
          cur_slot <= idx_rdata;
          state    <= S_CMP;
        end
        S_CMP: begin
          if (key_rdata == target) begin
            result.position <= pos_ext[6:0];
            state <= DONE;
          end else if (kv_less) begin
            lo <= nlo;
            if (nlo > hi) begin
              result.status <= ST_NOT_FOUND;
              state <= DONE;
            end else begin
              state <= S_MID;
            end
          end else begin
            hi <= nhi;
            if (lo > nhi) begin
              result.status <= ST_NOT_FOUND;
              state <= DONE;
            end else begin
              state <= S_MID;
            end
          end
        end
        DONE: begin
          if (done_ack) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sorted_key_index_search.sv -----
// A write or a stale search goes from IDLE straight to DONE, and its result then
// moves to the output register. Each halving step of a search passes through S_MID,
// S_KEY and S_CMP, for the dependent index read, key read and compare of the step.
// A build is an insertion sort: each key shift passes through B_PK and B_CMP, and
// each slot through B_START, B_KS, then B_PLACE or B_CMP; one item is in flight at a time.
// Reset clears the control state, sets entries_in_use to 128 and marks the index stale.
// ----------------------------------------------------------------------------
// sorted_key_index_search
// Keyed table with a sorted index built by insertion sort and a binary search.
// ----------------------------------------------------------------------------
module sorted_key_index_search
  import skis_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [7:0]       entries_in_use;
  logic [CNT_W-1:0] used;
  logic             seq_idle;
  logic             seq_done;
  logic             done_ack;
  out_item_t        seq_result;
  logic             cfg_wr;

  // Configuration is always taken; the contract only writes while idle.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  // Counts above the table depth act as the full table.
  assign used = (32'(entries_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(entries_in_use);

  // One item at a time: a new transfer is taken once the sequencer is back
  // in idle, which happens as soon as its result moves to the output register.
  assign in_ready = seq_idle;

  // The output register frees the sequencer while a result waits downstream.
  assign done_ack = seq_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        entries_in_use <= cfg_data;
      end
      if (done_ack) begin
        out_valid <= 1'b1;
        out_data  <= seq_result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  skis_seq #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && in_ready),
    .item     (in_data),
    .used     (used),
    .cfg_wr   (cfg_wr),
    .idle     (seq_idle),
    .done     (seq_done),
    .done_ack (done_ack),
    .result   (seq_result)
  );

endmodule
